// File: hw/rtl/gvs_pkg.sv
// Shared types, constants and helpers of the volume gradient stencil.
package gvs_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned GRAD_W    = 21;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_W     = 64;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRAL_MODE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 4'd3;

  // word kinds on the input tuser
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // floor(y/3) for |y| < 2^22: bias y by 3*2^22, multiply by ceil(2^26/3)
  localparam logic [24:0] DIV3_BIAS  = 25'd12582912;
  localparam logic [24:0] DIV3_RECIP = 25'd22369622;
  localparam logic signed [24:0] DIV3_UNBIAS = 25'sd4194304;
  localparam logic signed [24:0] GRAD_MAX = 25'sd1048575;
  localparam logic signed [24:0] GRAD_MIN = -25'sd1048576;

  typedef logic [2:0] slot_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] m2;
    logic signed [SAMPLE_W-1:0] m1;
    logic signed [SAMPLE_W-1:0] c;
    logic signed [SAMPLE_W-1:0] p1;
    logic signed [SAMPLE_W-1:0] p2;
  } taps_t;

  // which neighbors lie inside the volume
  typedef struct packed {
    logic m2;
    logic m1;
    logic p1;
    logic p2;
  } edge_t;

  function automatic slot_t mod5_add(slot_t a, slot_t b);
    logic [3:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd5) begin
      s = s - 4'd5;
    end
    return s[2:0];
  endfunction

  function automatic slot_t mod5_sub(slot_t a, slot_t b);
    logic [3:0] s;
    s = {1'b0, a} + 4'd5 - {1'b0, b};
    if (s >= 4'd5) begin
      s = s - 4'd5;
    end
    return s[2:0];
  endfunction

endpackage

// File: hw/rtl/volume_gradient_stencil.sv
// Top level of the streaming three-axis volume gradient stencil.
// Usage:
//   s_axis carries one word per voxel in raster order (column fastest, then
//   row, then layer). tuser selects push (sample in tdata) or drain tick.
//   m_axis returns the layer, row and column derivatives (signed Q.4) of the
//   next voxel whose neighborhood is complete; tlast marks the last voxel.
//   Each input word yields at most one result; drain ticks flush the tail.
//   The config port is written while the block is idle; any write of a known
//   register restarts the volume.
// Throughput: one word per cycle while s_axis_tready is high. Samples
//   sit in three banked copies of the plane buffers (banked by layer, by row
//   mod 5, column mod 5); one read per bank yields all thirteen taps at once.
// A result is registered at the bank read, in stage 2 and in the queue.
// Backpressure: a four-entry result queue sits ahead of m_axis; s_axis_tready
//   stays high while the queue plus words in flight leave room, so input is
//   taken while a result waits. Reset clears positions and the queue; the
//   sample memory is not cleared and a voxel is never read before written.
module volume_gradient_stencil #(
  parameter int unsigned MAX_ROWS    = 256,
  parameter int unsigned MAX_COLUMNS = 256,
  parameter int unsigned MAX_LAYERS  = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [gvs_pkg::SAMPLE_W-1:0]        s_axis_tdata,  // [15:0] sample
  input  logic                                s_axis_tuser,  // [0] operation
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [20:0] grad_layer, [41:21] grad_row, [62:42] grad_column, [63] zero
  output logic [gvs_pkg::OUT_W-1:0]           m_axis_tdata,
  output logic                                m_axis_tlast,  // final_voxel
  input  logic                                cfg_we_i,
  input  logic [gvs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [gvs_pkg::CFG_DAT_W-1:0]       cfg_data_i
);

  localparam int unsigned LW  = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned LNW = $clog2(MAX_LAYERS + 1);
  localparam int unsigned RNW = $clog2(MAX_ROWS + 1);
  localparam int unsigned CNW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RQN = (MAX_ROWS + 4) / 5;
  localparam int unsigned CQN = (MAX_COLUMNS + 4) / 5;
  localparam int unsigned RQW = (RQN > 1) ? $clog2(RQN) : 1;
  localparam int unsigned CQW = (CQN > 1) ? $clog2(CQN) : 1;
  localparam int unsigned PW  = RNW + CNW;
  localparam int unsigned LDW = $clog2(2 * MAX_ROWS * MAX_COLUMNS + 3) + 1;
  localparam int unsigned LAW = RW + CW;
  localparam int unsigned RAW = 3 + RQW + CW;
  localparam int unsigned CAW = 3 + RW + CQW;
  localparam int unsigned SW  = gvs_pkg::SAMPLE_W;
  localparam int unsigned GW  = gvs_pkg::GRAD_W;

  typedef struct packed {
    logic [LW-1:0]  l;
    logic [2:0]     slot;
    logic [RW-1:0]  r;
    logic [2:0]     rm;
    logic [RQW-1:0] rq;
    logic [CW-1:0]  c;
    logic [2:0]     cm;
    logic [CQW-1:0] cq;
  } pos_t;

  function automatic pos_t pos_next(pos_t p, logic last_c, logic last_r);
    pos_t n;
    n = p;
    if (!last_c) begin
      n.c = p.c + CW'(1);
      if (p.cm == 3'd4) begin
        n.cm = '0;
        n.cq = p.cq + CQW'(1);
      end else begin
        n.cm = p.cm + 3'd1;
      end
    end else begin
      n.c  = '0;
      n.cm = '0;
      n.cq = '0;
      if (!last_r) begin
        n.r = p.r + RW'(1);
        if (p.rm == 3'd4) begin
          n.rm = '0;
          n.rq = p.rq + RQW'(1);
        end else begin
          n.rm = p.rm + 3'd1;
        end
      end else begin
        n.r    = '0;
        n.rm   = '0;
        n.rq   = '0;
        n.l    = p.l + LW'(1);
        n.slot = gvs_pkg::mod5_add(p.slot, 3'd1);
      end
    end
    return n;
  endfunction

  // ---------------- configuration ----------------
  logic        mode_q;
  logic [12:0] layer_cnt_q;
  logic [8:0]  row_cnt_q, col_cnt_q;
  logic        cfg_hit;
  logic [LNW-1:0] nl;
  logic [RNW-1:0] nr;
  logic [CNW-1:0] nc;
  logic [PW-1:0]  plane;

  assign cfg_hit = cfg_we_i && ((cfg_index_i == gvs_pkg::CFG_CENTRAL_MODE) ||
                                (cfg_index_i == gvs_pkg::CFG_LAYER_COUNT) ||
                                (cfg_index_i == gvs_pkg::CFG_ROW_COUNT) ||
                                (cfg_index_i == gvs_pkg::CFG_COLUMN_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      layer_cnt_q <= 13'd1;
      row_cnt_q   <= 9'd1;
      col_cnt_q   <= 9'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gvs_pkg::CFG_CENTRAL_MODE: mode_q      <= cfg_data_i[0];
        gvs_pkg::CFG_LAYER_COUNT:  layer_cnt_q <= cfg_data_i;
        gvs_pkg::CFG_ROW_COUNT:    row_cnt_q   <= cfg_data_i[8:0];
        gvs_pkg::CFG_COLUMN_COUNT: col_cnt_q   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (layer_cnt_q == '0) nl = LNW'(1);
    else if (32'(layer_cnt_q) > MAX_LAYERS) nl = LNW'(MAX_LAYERS);
    else nl = LNW'(layer_cnt_q);
    if (row_cnt_q == '0) nr = RNW'(1);
    else if (32'(row_cnt_q) > MAX_ROWS) nr = RNW'(MAX_ROWS);
    else nr = RNW'(row_cnt_q);
    if (col_cnt_q == '0) nc = CNW'(1);
    else if (32'(col_cnt_q) > MAX_COLUMNS) nc = CNW'(MAX_COLUMNS);
    else nc = CNW'(col_cnt_q);
    plane = PW'(nr) * PW'(nc);
  end

  // ---------------- positions and emit decision ----------------
  pos_t wpos_q, epos_q;
  logic push_done_q, emit_done_q;
  logic [LDW-1:0] lead_q, lead_new;
  logic in_acc, push, emit;
  logic w_last_c, w_last_r, w_last_l, e_last_c, e_last_r, e_last_l, e_last;
  gvs_pkg::edge_t edge_l, edge_r, edge_c;
  logic [31:0] need_l, need_r, need_c;
  logic [2:0] fifo_cnt;
  logic s1_valid_q, s2_valid_q;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign push   = in_acc && (s_axis_tuser == gvs_pkg::OP_PUSH) && !push_done_q;

  assign w_last_c = (32'(wpos_q.c) + 32'd1 == 32'(nc));
  assign w_last_r = (32'(wpos_q.r) + 32'd1 == 32'(nr));
  assign w_last_l = (32'(wpos_q.l) + 32'd1 == 32'(nl));
  assign e_last_c = (32'(epos_q.c) + 32'd1 == 32'(nc));
  assign e_last_r = (32'(epos_q.r) + 32'd1 == 32'(nr));
  assign e_last_l = (32'(epos_q.l) + 32'd1 == 32'(nl));
  assign e_last   = e_last_c && e_last_r && e_last_l;

  always_comb begin
    edge_l.m1 = (epos_q.l != '0);
    edge_l.m2 = (32'(epos_q.l) >= 32'd2);
    edge_l.p1 = (32'(epos_q.l) + 32'd1 < 32'(nl));
    edge_l.p2 = (32'(epos_q.l) + 32'd2 < 32'(nl));
    edge_r.m1 = (epos_q.r != '0);
    edge_r.m2 = (32'(epos_q.r) >= 32'd2);
    edge_r.p1 = (32'(epos_q.r) + 32'd1 < 32'(nr));
    edge_r.p2 = (32'(epos_q.r) + 32'd2 < 32'(nr));
    edge_c.m1 = (epos_q.c != '0);
    edge_c.m2 = (32'(epos_q.c) >= 32'd2);
    edge_c.p1 = (32'(epos_q.c) + 32'd1 < 32'(nc));
    edge_c.p2 = (32'(epos_q.c) + 32'd2 < 32'(nc));
    // samples that must have arrived beyond the voxel itself
    need_l = (mode_q && edge_l.p2) ? 32'(plane) << 1 : (edge_l.p1 ? 32'(plane) : 32'd0);
    need_r = (mode_q && edge_r.p2) ? 32'(nc) << 1 : (edge_r.p1 ? 32'(nc) : 32'd0);
    need_c = (mode_q && edge_c.p2) ? 32'd2 : (edge_c.p1 ? 32'd1 : 32'd0);
    lead_new = lead_q + LDW'(push);
    emit = in_acc && !emit_done_q && (32'(lead_new) > need_l) &&
           (32'(lead_new) > need_r) && (32'(lead_new) > need_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q      <= '0;
      epos_q      <= '0;
      push_done_q <= 1'b0;
      emit_done_q <= 1'b0;
      lead_q      <= '0;
    end else if (cfg_hit) begin
      wpos_q      <= '0;
      epos_q      <= '0;
      push_done_q <= 1'b0;
      emit_done_q <= 1'b0;
      lead_q      <= '0;
    end else begin
      if (push) begin
        wpos_q <= pos_next(wpos_q, w_last_c, w_last_r);
        if (w_last_c && w_last_r && w_last_l) begin
          push_done_q <= 1'b1;
        end
      end
      if (emit) begin
        epos_q <= pos_next(epos_q, e_last_c, e_last_r);
        if (e_last) begin
          emit_done_q <= 1'b1;
        end
      end
      lead_q <= lead_new - LDW'(emit);
    end
  end

  // ---------------- banked plane buffers ----------------
  logic [SW-1:0] lay_rd [5];
  logic [SW-1:0] row_rd [5];
  logic [SW-1:0] col_rd [5];

  for (genvar b = 0; b < 5; b++) begin : g_bank
    gvs_pkg::slot_t rd_d, cd_d;
    logic [RQW-1:0] rq_t;
    logic [CQW-1:0] cq_t;

    always_comb begin
      rd_d = gvs_pkg::mod5_sub(3'(b), epos_q.rm);
      cd_d = gvs_pkg::mod5_sub(3'(b), epos_q.cm);
      rq_t = epos_q.rq;
      if ((rd_d == 3'd1 || rd_d == 3'd2) && (3'(b) < epos_q.rm)) rq_t = epos_q.rq + RQW'(1);
      if ((rd_d == 3'd3 || rd_d == 3'd4) && (3'(b) > epos_q.rm)) rq_t = epos_q.rq - RQW'(1);
      cq_t = epos_q.cq;
      if ((cd_d == 3'd1 || cd_d == 3'd2) && (3'(b) < epos_q.cm)) cq_t = epos_q.cq + CQW'(1);
      if ((cd_d == 3'd3 || cd_d == 3'd4) && (3'(b) > epos_q.cm)) cq_t = epos_q.cq - CQW'(1);
    end

    gvs_bank #(.AW(LAW)) u_lay (
      .clk_i   (clk_i),
      .we_i    (push && (wpos_q.slot == 3'(b))),
      .waddr_i ({wpos_q.r, wpos_q.c}),
      .wdata_i (s_axis_tdata),
      .raddr_i ({epos_q.r, epos_q.c}),
      .rdata_o (lay_rd[b])
    );

    gvs_bank #(.AW(RAW)) u_row (
      .clk_i   (clk_i),
      .we_i    (push && (wpos_q.rm == 3'(b))),
      .waddr_i ({wpos_q.slot, wpos_q.rq, wpos_q.c}),
      .wdata_i (s_axis_tdata),
      .raddr_i ({epos_q.slot, rq_t, epos_q.c}),
      .rdata_o (row_rd[b])
    );

    gvs_bank #(.AW(CAW)) u_col (
      .clk_i   (clk_i),
      .we_i    (push && (wpos_q.cm == 3'(b))),
      .waddr_i ({wpos_q.slot, wpos_q.r, wpos_q.cq}),
      .wdata_i (s_axis_tdata),
      .raddr_i ({epos_q.slot, epos_q.r, cq_t}),
      .rdata_o (col_rd[b])
    );
  end

  // ---------------- stage 1: bank data and voxel context ----------------
  gvs_pkg::slot_t s1_slot_q, s1_rm_q, s1_cm_q;
  gvs_pkg::edge_t s1_el_q, s1_er_q, s1_ec_q;
  logic s1_last_q, s2_last_q;
  gvs_pkg::taps_t taps_l, taps_r, taps_c;

  always_ff @(posedge clk_i) begin
    s1_slot_q <= epos_q.slot;
    s1_rm_q   <= epos_q.rm;
    s1_cm_q   <= epos_q.cm;
    s1_el_q   <= edge_l;
    s1_er_q   <= edge_r;
    s1_ec_q   <= edge_c;
    s1_last_q <= e_last;
    s2_last_q <= s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= emit;
      s2_valid_q <= s1_valid_q;
    end
  end

  // gather taps: offsets +1,+2,-2,-1 are +1,+2,+3,+4 modulo five
  always_comb begin
    taps_l.c  = lay_rd[s1_slot_q];
    taps_l.p1 = lay_rd[gvs_pkg::mod5_add(s1_slot_q, 3'd1)];
    taps_l.p2 = lay_rd[gvs_pkg::mod5_add(s1_slot_q, 3'd2)];
    taps_l.m2 = lay_rd[gvs_pkg::mod5_add(s1_slot_q, 3'd3)];
    taps_l.m1 = lay_rd[gvs_pkg::mod5_add(s1_slot_q, 3'd4)];
    taps_r.c  = row_rd[s1_rm_q];
    taps_r.p1 = row_rd[gvs_pkg::mod5_add(s1_rm_q, 3'd1)];
    taps_r.p2 = row_rd[gvs_pkg::mod5_add(s1_rm_q, 3'd2)];
    taps_r.m2 = row_rd[gvs_pkg::mod5_add(s1_rm_q, 3'd3)];
    taps_r.m1 = row_rd[gvs_pkg::mod5_add(s1_rm_q, 3'd4)];
    taps_c.c  = col_rd[s1_cm_q];
    taps_c.p1 = col_rd[gvs_pkg::mod5_add(s1_cm_q, 3'd1)];
    taps_c.p2 = col_rd[gvs_pkg::mod5_add(s1_cm_q, 3'd2)];
    taps_c.m2 = col_rd[gvs_pkg::mod5_add(s1_cm_q, 3'd3)];
    taps_c.m1 = col_rd[gvs_pkg::mod5_add(s1_cm_q, 3'd4)];
  end

  // ---------------- stage 2: per-axis arithmetic ----------------
  logic signed [GW-1:0] grad_l, grad_r, grad_c;

  gvs_axis u_axis_l (
    .clk_i(clk_i), .mode_i(mode_q), .taps_i(taps_l), .edge_i(s1_el_q), .grad_o(grad_l)
  );
  gvs_axis u_axis_r (
    .clk_i(clk_i), .mode_i(mode_q), .taps_i(taps_r), .edge_i(s1_er_q), .grad_o(grad_r)
  );
  gvs_axis u_axis_c (
    .clk_i(clk_i), .mode_i(mode_q), .taps_i(taps_c), .edge_i(s1_ec_q), .grad_o(grad_c)
  );

  // ---------------- result queue ----------------
  logic [gvs_pkg::OUT_W-1:0] fifo_out;

  gvs_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_valid_q),
    .data_i  ({s2_last_q, grad_c, grad_r, grad_l}),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (fifo_out),
    .count_o (fifo_cnt)
  );

  assign m_axis_tdata  = {1'b0, fifo_out[gvs_pkg::OUT_W-2:0]};
  assign m_axis_tlast  = fifo_out[gvs_pkg::OUT_W-1];
  // hold input while queued plus in-flight results could fill the queue
  assign s_axis_tready = (fifo_cnt + 3'(s1_valid_q) + 3'(s2_valid_q)) <
                         3'(gvs_pkg::OUT_DEPTH);

  // ---------------- assertions ----------------
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> ((fifo_cnt != 3'(gvs_pkg::OUT_DEPTH)) || m_axis_tready))
    else $error("result queue overflow");

  a_emit_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !emit_done_q)
    else $error("result emitted after the volume completed");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && e_last && !cfg_hit) |=> emit_done_q)
    else $error("volume not marked complete after last voxel");

  a_emit_needs_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (lead_new != '0))
    else $error("voxel emitted before its sample arrived");

  a_pipe_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> s2_valid_q)
    else $error("result lost between stages");

endmodule

// File: hw/rtl/gvs_bank.sv
// One sample bank: single write port, registered read with write-through.
module gvs_bank #(
  parameter int unsigned AW = 8
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [gvs_pkg::SAMPLE_W-1:0]  wdata_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [gvs_pkg::SAMPLE_W-1:0]  rdata_o
);

  logic [gvs_pkg::SAMPLE_W-1:0] mem [2**AW];
  logic [gvs_pkg::SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/gvs_axis.sv
// Derivative along one axis: edge replication, forward or five-tap central.
module gvs_axis (
  input  logic                               clk_i,
  input  logic                               mode_i,
  input  gvs_pkg::taps_t                     taps_i,
  input  gvs_pkg::edge_t                     edge_i,
  output logic signed [gvs_pkg::GRAD_W-1:0]  grad_o
);

  logic signed [gvs_pkg::SAMPLE_W-1:0] m2s, m1s, p1s, p2s;
  logic signed [16:0] diff;
  logic signed [21:0] num;
  logic signed [23:0] y;
  logic [24:0] z;
  logic [49:0] prod;
  logic [23:0] quot_d, quot_q;
  logic signed [gvs_pkg::GRAD_W-1:0] fwd_d, fwd_q;
  logic mode_q;
  logic signed [24:0] cen;

  always_comb begin
    // replicate the nearest sample inside the volume
    p1s  = edge_i.p1 ? taps_i.p1 : taps_i.c;
    p2s  = edge_i.p2 ? taps_i.p2 : p1s;
    m1s  = edge_i.m1 ? taps_i.m1 : taps_i.c;
    m2s  = edge_i.m2 ? taps_i.m2 : m1s;
    diff = 17'(p1s) - 17'(taps_i.c);
    fwd_d = {diff, 4'b0000};
    num  = 22'(m2s) - (22'(m1s) <<< 3) + (22'(p1s) <<< 3) - 22'(p2s);
    // floor((8*num+3)/6) == floor((4*num+1)/3)
    y    = (24'(num) <<< 2) + 24'sd1;
    z    = 25'(y) + gvs_pkg::DIV3_BIAS;
    prod = 50'(z) * 50'(gvs_pkg::DIV3_RECIP);
    quot_d = prod[49:26];
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    fwd_q  <= fwd_d;
    mode_q <= mode_i;
  end

  always_comb begin
    cen = $signed({1'b0, quot_q}) - gvs_pkg::DIV3_UNBIAS;
    if (!mode_q) begin
      grad_o = fwd_q;
    end else if (cen > gvs_pkg::GRAD_MAX) begin
      grad_o = gvs_pkg::GRAD_W'(gvs_pkg::GRAD_MAX);
    end else if (cen < gvs_pkg::GRAD_MIN) begin
      grad_o = gvs_pkg::GRAD_W'(gvs_pkg::GRAD_MIN);
    end else begin
      grad_o = cen[gvs_pkg::GRAD_W-1:0];
    end
  end

endmodule

// File: hw/rtl/gvs_out_fifo.sv
// Result queue in front of the output stream.
module gvs_out_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [gvs_pkg::OUT_W-1:0]  data_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [gvs_pkg::OUT_W-1:0]  data_o,
  output logic [2:0]                 count_o
);

  logic [gvs_pkg::OUT_W-1:0] store_q [gvs_pkg::OUT_DEPTH];
  logic [1:0] wptr_q, rptr_q;
  logic [2:0] cnt_q;
  logic pop;

  assign valid_o = (cnt_q != 3'd0);
  assign pop     = valid_o && ready_i;
  assign data_o  = store_q[rptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 2'd1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 2'd1;
      end
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop);
    end
  end

endmodule
